@@ hw/rtl/srtcfa_pkg.sv @@
// Package for the sorted range table frame-address lookup block.
// Holds request, status and state codes, the table entry layout and the
// register file control struct. No dependencies.
`default_nettype none

package srtcfa_pkg;

  // Request codes carried in req_type.
  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_WRITE  = 2'd2,
    REQ_UNWIND = 2'd3
  } req_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_FOUND  = 2'd1,
    ST_TABLE_FULL = 2'd2
  } status_t;

  // Frame rule codes. Other codes are stored as given and never match.
  localparam logic [1:0] RULE_REG_OFFSET = 2'd0;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_UNW_ENTRY,
    S_UNW_REG,
    S_DONE
  } state_t;

  // One table entry as stored in the range memory.
  typedef struct packed {
    logic [63:0]        range_start;
    logic [63:0]        range_end;
    logic [1:0]         rule;
    logic [5:0]         reg_idx;
    logic signed [63:0] offset;
  } entry_t;

  // Register file access from the sequencer.
  typedef struct packed {
    logic        wr_en;
    logic [5:0]  wr_idx;
    logic [63:0] wr_data;
    logic        rd_en;
    logic [5:0]  rd_idx;
  } rf_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/srtcfa_if.sv @@
// Valid/ready channel interfaces for requests and results.
// Depends on nothing but plain logic types.
`default_nettype none

// Request channel: one beat is one request.
interface srtcfa_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [63:0]        addr;
  logic [63:0]        range_end;
  logic [1:0]         rule;
  logic [5:0]         reg_index;
  logic signed [63:0] frame_offset;
  logic [63:0]        reg_value;

  modport source (output valid, req_type, addr, range_end, rule, reg_index, frame_offset,
                  reg_value, input ready);
  modport sink (input valid, req_type, addr, range_end, rule, reg_index, frame_offset,
                reg_value, output ready);
endinterface

// Result channel: one beat per request.
interface srtcfa_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] frame_addr;

  modport source (output valid, status, frame_addr, input ready);
  modport sink (input valid, status, frame_addr, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/sorted_range_table_cfa_lookup.sv @@
// Top level of the sorted range table frame-address lookup block.
// Depends on srtcfa_pkg, srtcfa_req_if, srtcfa_rsp_if and srtcfa_regfile.
//
//   Channel | Dir | Beat contents
//   --------+-----+---------------------------------------------------------
//   req     | in  | req_type, addr, range_end, rule, reg_index, frame_offset,
//           |     | reg_value
//   rsp     | out | status, frame_addr (one beat per request)
//
// A request is accepted only in idle and runs until its result is handed to
// the output register; clear and register write go straight to the hand-off.
// Unwind runs an upper-bound search, one table memory read per probe, then
// reads the found entry and its register. Insert runs the same search, then
// moves the entries from the insert position up by one and adds the new one.
// Reset empties the table and zeros the frame address and the register file.
// A stalled result waits in the output register while the next request runs.
`default_nettype none

module sorted_range_table_cfa_lookup #(
  parameter int TABLE_ENTRIES = 256,
  parameter int NUM_REGS      = 32
) (
  input  wire         clk,
  input  wire         rst,
  srtcfa_req_if.sink   req,
  srtcfa_rsp_if.source rsp
);
  import srtcfa_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = IDX_W + 1;

  // Table memory and its ports.
  entry_t             tbl_mem [TABLE_ENTRIES];
  entry_t             mem_rdata;
  entry_t             mem_wdata;
  logic               mem_we;
  logic               mem_re;
  logic [IDX_W-1:0]   mem_waddr;
  logic [IDX_W-1:0]   mem_raddr;

  // Sequencer registers.
  state_t             state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [CNT_W-1:0]   lo, lo_next;
  logic [CNT_W-1:0]   hi, hi_next;
  logic [CNT_W-1:0]   mid, mid_next;
  logic [CNT_W-1:0]   pos, pos_next;
  logic [CNT_W-1:0]   cur, cur_next;
  logic               rd_pend, rd_pend_next;
  status_t            status, status_next;
  logic [63:0]        frame_addr, frame_addr_next;
  logic               is_insert, is_insert_next;

  // Latched request payload.
  logic [63:0]        key;
  logic [63:0]        rend_q;
  logic [1:0]         rule_q;
  logic [5:0]         ridx_q;
  logic signed [63:0] off_q, off_next;

  // Output register.
  logic               rsp_valid;
  logic [1:0]         rsp_status;
  logic [63:0]        rsp_frame;
  logic               rsp_load;

  // Register file.
  rf_ctl_t            rf_ctl;
  logic [63:0]        rf_rdata;

  // Search step scratch.
  logic [CNT_W-1:0]   lo_c, hi_c, mid_c, cur_m1;
  logic               accept;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);

  srtcfa_regfile #(
    .NUM_REGS (NUM_REGS)
  ) u_regfile (
    .clk     (clk),
    .rst     (rst),
    .ctl     (rf_ctl),
    .rd_data (rf_rdata)
  );

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tbl_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_rdata <= tbl_mem[mem_raddr];
    end
  end

  // Next state, memory accesses and result for each sequencer state.
  always_comb begin
    state_next      = state;
    count_next      = count;
    lo_next         = lo;
    hi_next         = hi;
    mid_next        = mid;
    pos_next        = pos;
    cur_next        = cur;
    rd_pend_next    = rd_pend;
    status_next     = status;
    frame_addr_next = frame_addr;
    is_insert_next  = is_insert;
    off_next        = off_q;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    mem_waddr       = cur[IDX_W-1:0];
    mem_raddr       = mid[IDX_W-1:0];
    mem_wdata       = mem_rdata;
    rf_ctl          = '0;
    rsp_load        = 1'b0;
    lo_c            = lo;
    hi_c            = hi;
    mid_c           = mid;
    cur_m1          = cur - CNT_W'(1);

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          off_next       = req.frame_offset;
          lo_next        = '0;
          hi_next        = count;
          rd_pend_next   = 1'b0;
          is_insert_next = 1'b0;
          status_next    = ST_OK;
          unique case (req_t'(req.req_type))
            REQ_CLEAR: begin
              count_next = '0;
              state_next = S_DONE;
            end
            REQ_INSERT: begin
              if (count >= CNT_W'(TABLE_ENTRIES)) begin
                status_next = ST_TABLE_FULL;
                state_next  = S_DONE;
              end else begin
                is_insert_next = 1'b1;
                state_next     = S_SEARCH;
              end
            end
            REQ_WRITE: begin
              rf_ctl.wr_en   = ({1'b0, req.reg_index} < 7'(NUM_REGS));
              rf_ctl.wr_idx  = req.reg_index;
              rf_ctl.wr_data = req.reg_value;
              state_next     = S_DONE;
            end
            REQ_UNWIND: begin
              state_next = S_SEARCH;
            end
          endcase
        end
      end

      // Upper-bound search: fold in the last probe, then issue the next one.
      S_SEARCH: begin
        if (rd_pend) begin
          if (mem_rdata.range_start <= key) begin
            lo_c = mid + CNT_W'(1);
          end else begin
            hi_c = mid;
          end
        end
        lo_next = lo_c;
        hi_next = hi_c;
        if (lo_c < hi_c) begin
          mid_c        = lo_c + ((hi_c - lo_c) >> 1);
          mid_next     = mid_c;
          mem_re       = 1'b1;
          mem_raddr    = mid_c[IDX_W-1:0];
          rd_pend_next = 1'b1;
        end else begin
          rd_pend_next = 1'b0;
          pos_next     = lo_c;
          if (is_insert) begin
            cur_next   = count;
            state_next = S_SHIFT;
          end else if (lo_c == '0) begin
            status_next = ST_NOT_FOUND;
            state_next  = S_DONE;
          end else begin
            mid_c      = lo_c - CNT_W'(1);
            mem_re     = 1'b1;
            mem_raddr  = mid_c[IDX_W-1:0];
            state_next = S_UNW_ENTRY;
          end
        end
      end

      // Move entries at and above the insert position up by one, one a cycle.
      S_SHIFT: begin
        if (rd_pend) begin
          mem_we    = 1'b1;
          mem_waddr = cur[IDX_W-1:0];
          mem_wdata = mem_rdata;
          cur_next  = cur_m1;
          if (cur_m1 > pos) begin
            mid_c     = cur_m1 - CNT_W'(1);
            mem_re    = 1'b1;
            mem_raddr = mid_c[IDX_W-1:0];
          end else begin
            rd_pend_next = 1'b0;
          end
        end else if (cur > pos) begin
          mem_re       = 1'b1;
          mem_raddr    = cur_m1[IDX_W-1:0];
          rd_pend_next = 1'b1;
        end else begin
          mem_we                = 1'b1;
          mem_waddr             = pos[IDX_W-1:0];
          mem_wdata.range_start = key;
          mem_wdata.range_end   = rend_q;
          mem_wdata.rule        = rule_q;
          mem_wdata.reg_idx     = ridx_q;
          mem_wdata.offset      = off_q;
          count_next            = count + CNT_W'(1);
          status_next           = ST_OK;
          state_next            = S_DONE;
        end
      end

      // Check the found entry and fetch its register if its index is in range.
      S_UNW_ENTRY: begin
        if (key >= mem_rdata.range_end || mem_rdata.rule != RULE_REG_OFFSET) begin
          status_next = ST_NOT_FOUND;
          state_next  = S_DONE;
        end else if ({1'b0, mem_rdata.reg_idx} >= 7'(NUM_REGS)) begin
          status_next = ST_OK;
          state_next  = S_DONE;
        end else begin
          rf_ctl.rd_en  = 1'b1;
          rf_ctl.rd_idx = mem_rdata.reg_idx;
          off_next      = mem_rdata.offset;
          state_next    = S_UNW_REG;
        end
      end

      S_UNW_REG: begin
        frame_addr_next = rf_rdata + $unsigned(off_q);
        status_next     = ST_OK;
        state_next      = S_DONE;
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!rsp_valid || rsp.ready) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      rd_pend    <= 1'b0;
      frame_addr <= 64'd0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      rd_pend    <= rd_pend_next;
      frame_addr <= frame_addr_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Working registers and payload.
  always_ff @(posedge clk) begin
    lo        <= lo_next;
    hi        <= hi_next;
    mid       <= mid_next;
    pos       <= pos_next;
    cur       <= cur_next;
    status    <= status_next;
    is_insert <= is_insert_next;
    off_q     <= off_next;
    if (accept) begin
      key    <= req.addr;
      rend_q <= req.range_end;
      rule_q <= req.rule;
      ridx_q <= req.reg_index;
    end
    if (rsp_load) begin
      rsp_status <= status;
      rsp_frame  <= frame_addr;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.status     = rsp_status;
  assign rsp.frame_addr = rsp_frame;

endmodule

`default_nettype wire

@@ hw/rtl/srtcfa_regfile.sv @@
// Register file for the frame-address lookup: a synchronous memory with one
// write and one read port, plus valid bits so unwritten registers read zero.
// Depends on srtcfa_pkg.
`default_nettype none

module srtcfa_regfile #(
  parameter int NUM_REGS = 32
) (
  input  wire                   clk,
  input  wire                   rst,
  input  srtcfa_pkg::rf_ctl_t   ctl,
  output logic [63:0]           rd_data
);
  import srtcfa_pkg::*;

  localparam int RIDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  logic [63:0]         rf_mem [NUM_REGS];
  logic [NUM_REGS-1:0] written;
  logic [63:0]         rd_q;
  logic                rd_vld;

  // Storage write port.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      rf_mem[ctl.wr_idx[RIDX_W-1:0]] <= ctl.wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_q <= rf_mem[ctl.rd_idx[RIDX_W-1:0]];
    end
  end

  // Written flags stand in for the all-zero reset of the storage.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        written[ctl.wr_idx[RIDX_W-1:0]] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_vld <= written[ctl.rd_idx[RIDX_W-1:0]];
      end
    end
  end

  assign rd_data = rd_vld ? rd_q : 64'd0;

endmodule

`default_nettype wire
